@@ rtl/sfa_pkg.sv @@
`timescale 1ns / 1ps
package sfa_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int ADDR_BITS_DEF   = 16;

  // request type codes as they arrive on the stream
  localparam logic [2:0] RT_CLEAR  = 3'd0;
  localparam logic [2:0] RT_APPEND = 3'd1;
  localparam logic [2:0] RT_ALLOC  = 3'd2;
  localparam logic [2:0] RT_FREE   = 3'd3;
  localparam logic [2:0] RT_READ   = 3'd4;

  // decoded request kinds handed from front to back
  localparam logic [2:0] K_CLEAR  = 3'd0;
  localparam logic [2:0] K_APPEND = 3'd1;
  localparam logic [2:0] K_ALLOC  = 3'd2;
  localparam logic [2:0] K_FREE   = 3'd3;
  localparam logic [2:0] K_READ   = 3'd4;
  localparam logic [2:0] K_BAD    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

  // configuration register indexes
  localparam logic REG_MEMORY_SIZE = 1'b0;
  localparam logic REG_FIT_POLICY  = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pid;
    logic [7:0]  sid;
    logic [15:0] addr;
    logic [15:0] size;
    logic [5:0]  idx;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_start;
    logic [15:0] out_end;
    logic [7:0]  out_owner;
    logic [7:0]  out_segment;
  } res_t;

endpackage

@@ rtl/sfa_ram.sv @@
`timescale 1ns / 1ps
module sfa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sfa_front.sv @@
`timescale 1ns / 1ps
module sfa_front
  import sfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  process_id,
  input  logic [7:0]  segment_id,
  input  logic [15:0] region_addr,
  input  logic [15:0] req_size,
  input  logic [5:0]  entry_index,
  input  logic        last_segment,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_data
);

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [2:0] kind;
  logic       push;
  logic       pop;

  always_comb begin
    unique case (req_type)
      RT_CLEAR:  kind = K_CLEAR;
      RT_APPEND: kind = K_APPEND;
      RT_ALLOC:  kind = K_ALLOC;
      RT_FREE:   kind = K_FREE;
      RT_READ:   kind = K_READ;
      default:   kind = K_BAD;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: kind, pid: process_id, sid: segment_id, addr: region_addr,
                        size: req_size, idx: entry_index, last: last_segment};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/sfa_engine.sv @@
`timescale 1ns / 1ps
module sfa_engine
  import sfa_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] memory_size,
  input  logic        fit_policy,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_data,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  output logic [6:0]  region_count
);

  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int EW = 2 * AW + 16;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_APW  = 4'd2;
  localparam logic [3:0] S_COPY = 4'd3;
  localparam logic [3:0] S_FIND = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_SHR  = 4'd6;
  localparam logic [3:0] S_SHW  = 4'd7;
  localparam logic [3:0] S_WR0  = 4'd8;
  localparam logic [3:0] S_WR1  = 4'd9;
  localparam logic [3:0] S_FREE = 4'd10;
  localparam logic [3:0] S_FFIN = 4'd11;
  localparam logic [3:0] S_FOUT = 4'd12;

  logic [3:0]    state;
  logic [3:0]    ret_state;
  req_t          req;
  logic [CW-1:0] count;
  logic [CW-1:0] snap_count;
  logic [7:0]    pend;
  logic          fail;
  logic [CW-1:0] k;
  logic [CW-1:0] n;
  logic [CW-1:0] wp;
  logic [CW-1:0] copy_n;
  logic          copy_dir;   // 0 table to snapshot, 1 snapshot to table
  logic [2:0]    fail_st;
  logic          found;
  logic [IW-1:0] best;
  logic [AW-1:0] best_start;
  logic [AW-1:0] best_end;
  logic          cur_v;
  logic [AW-1:0] cur_start;
  logic [AW-1:0] cur_end;
  logic [7:0]    cur_own;
  logic [7:0]    cur_seg;

  // table and snapshot memories
  logic          t_we, s_we;
  logic [IW-1:0] t_wa, s_wa, t_ra, s_ra;
  logic [EW-1:0] t_wd, s_wd, t_rd, s_rd;

  sfa_ram #(.WIDTH(EW), .DEPTH(MAX_REGIONS)) u_table (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  sfa_ram #(.WIDTH(EW), .DEPTH(MAX_REGIONS)) u_snap (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  logic [AW-1:0] e_start, e_end;
  logic [7:0]    e_own, e_seg, f_own, f_seg;
  logic [AW-1:0] a_addr, a_size, a_len, best_len;
  logic [AW:0]   a_end;
  logic          start;
  logic          append_bad;
  logic          hole_ok;
  logic          take;
  logic          merge;
  logic          split;
  logic          last_k;

  assign e_start  = t_rd[EW-1 -: AW];
  assign e_end    = t_rd[EW-1-AW -: AW];
  assign e_own    = t_rd[15:8];
  assign e_seg    = t_rd[7:0];
  assign f_own    = (e_own == req.pid) ? 8'd0 : e_own;
  assign f_seg    = (e_own == req.pid) ? 8'd0 : e_seg;
  assign a_addr   = AW'(q_data.addr);
  assign a_size   = AW'(state == S_IDLE ? q_data.size : req.size);
  assign a_end    = {1'b0, a_addr} + {1'b0, a_size};
  assign a_len    = e_end - e_start;
  assign best_len = best_end - best_start;
  assign start    = (state == S_IDLE) && q_valid && !res_valid;
  assign q_ready  = (state == S_IDLE) && !res_valid;
  assign append_bad = 33'(a_end) > 33'(memory_size);
  assign hole_ok  = (e_own == 8'd0) && (e_end >= e_start) && (a_len >= a_size);
  assign take     = hole_ok && (!found || (fit_policy && a_len < best_len));
  assign merge    = cur_v && (cur_own == 8'd0) && (f_own == 8'd0);
  assign split    = best_len != a_size;
  assign last_k   = (k == count);
  assign region_count = 7'(count);

  // memory port control
  always_comb begin
    t_we = 1'b0;
    t_wa = '0;
    t_wd = '0;
    s_we = 1'b0;
    s_wa = '0;
    s_wd = '0;
    t_ra = '0;
    s_ra = '0;
    unique case (state)
      S_IDLE: begin
        if (start && q_data.kind == K_READ) begin
          t_ra = IW'(q_data.idx);
        end else if (start && q_data.kind == K_APPEND) begin
          t_ra = IW'(count - 1'b1);
          if (count == '0 && !append_bad) begin
            t_we = 1'b1;
            t_wd = {a_addr, AW'(a_end), q_data.pid, q_data.sid};
          end
        end
      end
      S_APW: begin
        t_wa = IW'(count);
        t_wd = {AW'(req.addr), AW'({1'b0, AW'(req.addr)} + {1'b0, a_size}), req.pid, req.sid};
        t_we = (AW'(req.addr) >= e_end);
      end
      S_COPY: begin
        t_ra = IW'(k);
        s_ra = IW'(k);
        if (k != '0) begin
          if (copy_dir) begin
            t_we = 1'b1;
            t_wa = IW'(k - 1'b1);
            t_wd = s_rd;
          end else begin
            s_we = 1'b1;
            s_wa = IW'(k - 1'b1);
            s_wd = t_rd;
          end
        end
      end
      S_FIND: t_ra = IW'(k);
      S_SHR:  t_ra = IW'(n - 1'b1);
      S_SHW: begin
        t_we = 1'b1;
        t_wa = IW'(n);
        t_wd = t_rd;
      end
      S_WR0: begin
        t_we = 1'b1;
        t_wa = best;
        t_wd = {best_start, best_start + a_size, req.pid, req.sid};
      end
      S_WR1: begin
        t_we = 1'b1;
        t_wa = best + 1'b1;
        t_wd = {best_start + a_size, best_end, 8'd0, 8'd0};
      end
      S_FREE: begin
        t_ra = IW'(k);
        t_wa = IW'(wp);
        t_wd = {cur_start, cur_end, cur_own, cur_seg};
        t_we = (k != '0) && cur_v && !merge;
      end
      S_FFIN: begin
        t_wa = IW'(wp);
        t_wd = {cur_start, cur_end, cur_own, cur_seg};
        t_we = cur_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      count     <= '0;
      pend      <= 8'd0;
      fail      <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= q_data;
            unique case (q_data.kind)
              K_CLEAR: begin
                count     <= '0;
                pend      <= 8'd0;
                fail      <= 1'b0;
                res       <= '{status: ST_OK, default: '0};
                res_valid <= 1'b1;
              end
              K_READ: begin
                if (32'(q_data.idx) >= 32'(count)) begin
                  res       <= '{status: ST_BAD, default: '0};
                  res_valid <= 1'b1;
                end else begin
                  state <= S_RDW;
                end
              end
              K_APPEND: begin
                pend <= 8'd0;
                fail <= 1'b0;
                if (32'(count) >= 32'(MAX_REGIONS)) begin
                  res       <= '{status: ST_FULL, default: '0};
                  res_valid <= 1'b1;
                end else if (append_bad) begin
                  res       <= '{status: ST_BAD, default: '0};
                  res_valid <= 1'b1;
                end else if (count == '0) begin
                  count     <= count + 1'b1;
                  res       <= '{status: ST_OK, out_start: 16'(a_addr),
                                 out_end: 16'(AW'(a_end)), out_owner: q_data.pid,
                                 out_segment: q_data.sid};
                  res_valid <= 1'b1;
                end else begin
                  state <= S_APW;
                end
              end
              K_FREE: begin
                pend  <= 8'd0;
                fail  <= 1'b0;
                k     <= '0;
                wp    <= '0;
                cur_v <= 1'b0;
                state <= S_FREE;
              end
              K_ALLOC: begin
                k     <= '0;
                found <= 1'b0;
                if (q_data.pid == 8'd0) begin
                  res       <= '{status: ST_NOFIT, default: '0};
                  res_valid <= 1'b1;
                end else if (pend != 8'd0 && q_data.pid == pend && fail) begin
                  if (q_data.last) begin
                    pend <= 8'd0;
                    fail <= 1'b0;
                  end
                  res       <= '{status: ST_IGNORED, default: '0};
                  res_valid <= 1'b1;
                end else if (q_data.pid != pend) begin
                  pend      <= q_data.pid;
                  fail      <= 1'b0;
                  ret_state <= S_FIND;
                  state     <= S_COPY;
                  if (pend != 8'd0 && !fail) begin
                    // open transaction rolls back; snapshot then already matches
                    copy_dir <= 1'b1;
                    copy_n   <= snap_count;
                  end else begin
                    copy_dir   <= 1'b0;
                    copy_n     <= count;
                    snap_count <= count;
                  end
                end else begin
                  state <= S_FIND;
                end
              end
              default: begin
                res       <= '{status: ST_BAD, default: '0};
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RDW: begin
          state <= S_IDLE;
          res   <= '{status: ST_OK, out_start: 16'(e_start), out_end: 16'(e_end),
                     out_owner: e_own, out_segment: e_seg};
          res_valid <= 1'b1;
        end
        S_APW: begin
          state <= S_IDLE;
          if (AW'(req.addr) < e_end) begin
            res <= '{status: ST_BAD, default: '0};
          end else begin
            count <= count + 1'b1;
            res   <= '{status: ST_OK, out_start: 16'(AW'(req.addr)),
                       out_end: 16'(AW'({1'b0, AW'(req.addr)} + {1'b0, a_size})),
                       out_owner: req.pid, out_segment: req.sid};
          end
          res_valid <= 1'b1;
        end
        S_COPY: begin
          if (k == copy_n) begin
            k     <= '0;
            found <= 1'b0;
            state <= ret_state;
            if (copy_dir) count <= snap_count;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FIND: begin
          if (k != '0 && take) begin
            found      <= 1'b1;
            best       <= IW'(k - 1'b1);
            best_start <= e_start;
            best_end   <= e_end;
          end
          if (last_k) state <= S_DEC;
          else        k <= k + 1'b1;
        end
        S_DEC: begin
          if (!found || (split && 32'(count) >= 32'(MAX_REGIONS))) begin
            fail_st   <= found ? ST_FULL : ST_NOFIT;
            copy_dir  <= 1'b1;
            copy_n    <= snap_count;
            k         <= '0;
            ret_state <= S_FOUT;
            state     <= S_COPY;
          end else if (split && 32'(count) > 32'(best) + 1) begin
            n     <= count;
            state <= S_SHR;
          end else begin
            state <= S_WR0;
          end
        end
        S_SHR: state <= S_SHW;
        S_SHW: begin
          n <= n - 1'b1;
          if (32'(n) - 1 > 32'(best) + 1) state <= S_SHR;
          else                            state <= S_WR0;
        end
        S_WR0, S_WR1: begin
          if (state == S_WR0 && split) begin
            state <= S_WR1;
          end else begin
            if (state == S_WR1) count <= count + 1'b1;
            if (req.last) pend <= 8'd0;
            res <= '{status: ST_OK, out_start: 16'(best_start),
                     out_end: 16'(best_start + a_size),
                     out_owner: req.pid, out_segment: req.sid};
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FREE: begin
          if (k != '0) begin
            if (merge) begin
              cur_end <= e_end;
            end else begin
              if (cur_v) wp <= wp + 1'b1;
              cur_start <= e_start;
              cur_end   <= e_end;
              cur_own   <= f_own;
              cur_seg   <= f_seg;
              cur_v     <= 1'b1;
            end
          end
          if (last_k) state <= S_FFIN;
          else        k <= k + 1'b1;
        end
        S_FFIN: begin
          count     <= wp + CW'(cur_v);
          res       <= '{status: ST_OK, default: '0};
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_FOUT: begin
          if (req.last) pend <= 8'd0;
          else          fail <= 1'b1;
          res       <= '{status: fail_st, default: '0};
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_REGIONS)) else $error("region count beyond table");
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !res_valid) else $error("result pending while busy");
  a_fail_needs_pend: assert property (@(posedge clk) disable iff (rst)
    fail |-> pend != 8'd0) else $error("failure flag without open process");
  a_result_holds_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(count)) else $error("count moved under result");

endmodule

@@ rtl/segment_fit_allocator.sv @@
`timescale 1ns / 1ps
// Segment allocator over an address-ordered table of up to MAX_REGIONS regions
// (start, end, owner, segment; owner 0 is a hole). Each request on the slave
// stream yields exactly one result on the master stream. A two-entry request
// queue decouples the input from the allocation engine, so a new item is
// taken while a result waits. Items run one at a time in the engine; its
// table memory, one read and one write port, sets the steps: a read fetches
// one entry, an append checks the last, a free scans and merges holes, and
// an allocate copies a snapshot or rolls back, scans for a hole, shifts each
// later entry (a read, a write), writes one or two entries; a failure skips
// the shift and rolls back instead. The user writes configuration (memory_size
// at 0x0, fit_policy at 0x4) only while idle; the block does not enforce it.
module segment_fit_allocator
  import sfa_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // process_id, segment_id, region_addr, req_size, entry_index
  input  logic [2:0]  s_tuser,  // req_type
  input  logic        s_tlast,  // last_segment
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // out_start, out_end, out_owner, out_segment, region_count
  output logic [2:0]  m_tuser,  // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] memory_size;
  logic        fit_policy;
  logic        q_valid;
  logic        q_ready;
  req_t        q_data;
  res_t        res;
  logic [6:0]  region_count;

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIT_POLICY) ? {31'd0, fit_policy} : {16'd0, memory_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= 16'd0;
      fit_policy  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_MEMORY_SIZE: memory_size <= pwdata[15:0];
        REG_FIT_POLICY:  fit_policy  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  sfa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .req_type    (s_tuser),
    .process_id  (s_tdata[7:0]),
    .segment_id  (s_tdata[15:8]),
    .region_addr (s_tdata[31:16]),
    .req_size    (s_tdata[47:32]),
    .entry_index (s_tdata[53:48]),
    .last_segment(s_tlast),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_data      (q_data)
  );

  // back: table engine with result register
  sfa_engine #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .memory_size (memory_size),
    .fit_policy  (fit_policy),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_data      (q_data),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res         (res),
    .region_count(region_count)
  );

  assign m_tuser = res.status;
  assign m_tdata = {1'b0, region_count, res.out_segment, res.out_owner,
                    res.out_end, res.out_start};

endmodule

@@ dv/sfa_checker.sv @@
`timescale 1ns / 1ps
module sfa_checker
  import sfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          outstanding,
  output int          fails
);

  typedef struct {
    logic [15:0] base;
    logic [15:0] limit;
    logic [7:0]  owner;
    logic [7:0]  seg;
  } region_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] rstart;
    logic [15:0] rend;
    logic [7:0]  owner;
    logic [7:0]  seg;
    logic [6:0]  count;
  } alloc_res_t;

  region_t     map_tbl [64];
  region_t     snap_tbl[64];
  int unsigned map_cnt, snap_cnt;
  logic [7:0]  open_pid;
  logic        open_failed;
  logic [15:0] mem_size;
  logic        best_fit;
  alloc_res_t  results_due[$];

  function automatic alloc_res_t mk(logic [2:0] st, logic [15:0] a, logic [15:0] b,
                                    logic [7:0] o, logic [7:0] g);
    alloc_res_t r;
    r.status = st; r.rstart = a; r.rend = b; r.owner = o; r.seg = g;
    r.count = map_cnt[6:0];
    return r;
  endfunction

  // one request through the allocator's table
  task automatic apply_request(input logic [2:0] kind, input logic [55:0] d, input logic last,
                               output alloc_res_t r);
    logic [7:0]  pid;
    logic [7:0]  sid;
    logic [15:0] addr;
    logic [15:0] size;
    logic [5:0]  idx;
    int unsigned lim, at, best_len, len, w;
    logic [2:0]  st;
    logic        found;
    region_t     e;
    pid = d[7:0]; sid = d[15:8]; addr = d[31:16]; size = d[47:32]; idx = d[53:48];
    case (kind)
      RT_CLEAR: begin
        map_cnt = 0; open_pid = 0; open_failed = 0;
        r = mk(ST_OK, 0, 0, 0, 0);
      end
      RT_APPEND: begin
        lim = addr + size;
        open_pid = 0; open_failed = 0;
        if (map_cnt >= 64) r = mk(ST_FULL, 0, 0, 0, 0);
        else if (lim > mem_size || (map_cnt > 0 && addr < map_tbl[map_cnt-1].limit))
          r = mk(ST_BAD, 0, 0, 0, 0);
        else begin
          map_tbl[map_cnt] = '{addr, lim[15:0], pid, sid};
          map_cnt++;
          r = mk(ST_OK, addr, lim[15:0], pid, sid);
        end
      end
      RT_ALLOC: begin
        if (pid == 0) begin
          r = mk(ST_NOFIT, 0, 0, 0, 0);
          return;
        end
        if (open_pid != 0 && pid == open_pid && open_failed) begin
          if (last) begin open_pid = 0; open_failed = 0; end
          r = mk(ST_IGNORED, 0, 0, 0, 0);
          return;
        end
        if (pid != open_pid) begin
          // a different process abandons the open one
          if (open_pid != 0 && !open_failed) begin map_tbl = snap_tbl; map_cnt = snap_cnt; end
          snap_tbl = map_tbl; snap_cnt = map_cnt;
          open_pid = pid; open_failed = 0;
        end
        found = 0; at = 0; best_len = 0;
        for (int i = 0; i < map_cnt; i++) begin
          if (map_tbl[i].owner != 0 || map_tbl[i].limit < map_tbl[i].base) continue;
          len = map_tbl[i].limit - map_tbl[i].base;
          if (len < size) continue;
          if (!found || (best_fit && len < best_len)) begin
            found = 1; at = i; best_len = len;
            if (!best_fit) break;
          end
        end
        st = ST_OK;
        if (!found) st = ST_NOFIT;
        else if (best_len != size && map_cnt >= 64) st = ST_FULL;
        if (st != ST_OK) begin
          map_tbl = snap_tbl; map_cnt = snap_cnt;
          if (last) open_pid = 0;
          else open_failed = 1;
          r = mk(st, 0, 0, 0, 0);
          return;
        end
        if (best_len != size) begin
          for (int j = map_cnt - 1; j > int'(at); j--) map_tbl[j+1] = map_tbl[j];
          map_tbl[at+1] = '{map_tbl[at].base + size, map_tbl[at].limit, 8'd0, 8'd0};
          map_tbl[at].limit = map_tbl[at].base + size;
          map_cnt++;
        end
        map_tbl[at].owner = pid;
        map_tbl[at].seg = sid;
        if (last) open_pid = 0;
        r = mk(ST_OK, map_tbl[at].base, map_tbl[at].limit, pid, sid);
      end
      RT_FREE: begin
        open_pid = 0; open_failed = 0; w = 0;
        for (int i = 0; i < map_cnt; i++) begin
          e = map_tbl[i];
          if (e.owner == pid) begin e.owner = 0; e.seg = 0; end
          // adjacent holes collapse into the earlier one
          if (e.owner == 0 && w > 0 && map_tbl[w-1].owner == 0) map_tbl[w-1].limit = e.limit;
          else begin map_tbl[w] = e; w++; end
        end
        map_cnt = w;
        r = mk(ST_OK, 0, 0, 0, 0);
      end
      RT_READ: begin
        if (idx >= map_cnt) r = mk(ST_BAD, 0, 0, 0, 0);
        else r = mk(ST_OK, map_tbl[idx].base, map_tbl[idx].limit, map_tbl[idx].owner,
                    map_tbl[idx].seg);
      end
      default: r = mk(ST_BAD, 0, 0, 0, 0);
    endcase
  endtask

  always @(posedge clk) begin
    alloc_res_t exp_r, got;
    if (rst) begin
      map_cnt <= 0; snap_cnt <= 0; open_pid <= 0; open_failed <= 0;
      mem_size <= 0; best_fit <= 0; fails <= 0; outstanding <= 0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_MEMORY_SIZE, 2'b00}) mem_size = pwdata[15:0];
        else if (paddr == {REG_FIT_POLICY, 2'b00}) best_fit = pwdata[0];
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32], m_tdata[47:40],
                m_tdata[54:48]};
        if (results_due.size() == 0) begin
          $error("result item with no request pending");
          fails = fails + 1;
        end else begin
          exp_r = results_due.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); fails = fails + 1;
          end
          if (got.rstart !== exp_r.rstart) begin
            $error("out_start exp %0d got %0d", exp_r.rstart, got.rstart); fails = fails + 1;
          end
          if (got.rend !== exp_r.rend) begin
            $error("out_end exp %0d got %0d", exp_r.rend, got.rend); fails = fails + 1;
          end
          if (got.owner !== exp_r.owner) begin
            $error("out_owner exp %0d got %0d", exp_r.owner, got.owner); fails = fails + 1;
          end
          if (got.seg !== exp_r.seg) begin
            $error("out_segment exp %0d got %0d", exp_r.seg, got.seg); fails = fails + 1;
          end
          if (got.count !== exp_r.count) begin
            $error("region_count exp %0d got %0d", exp_r.count, got.count); fails = fails + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser, s_tdata, s_tlast, exp_r);
        results_due.push_back(exp_r);
      end
      outstanding <= results_due.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import sfa_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [55:0] s_tdata;   // process_id, segment_id, region_addr, req_size, entry_index
  logic [2:0]  s_tuser;   // req_type
  logic        m_tvalid, m_tready;
  logic [55:0] m_tdata;   // out_start, out_end, out_owner, out_segment, region_count
  logic [2:0]  m_tuser;   // status
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          outstanding, fails;

  // stimulus bookkeeping
  int          items_sent;
  bit          no_idle;      // phases with back-to-back traffic on both sides
  int          sink_wait;
  logic [15:0] cur_mem;

  segment_fit_allocator dut (.*);

  sfa_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // generous cap: covers worst-case allocates plus both stalls
  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side: a fresh stall draw for every item taken
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      sink_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      sink_wait = no_idle ? 0 : $urandom_range(0, 3);
      if (sink_wait != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (sink_wait <= 1) m_tready <= 1'b1;
      sink_wait--;
    end
  end

  task automatic send(input int unsigned kind, input int unsigned pid, input int unsigned sid,
                      input int unsigned addr, input int unsigned size, input int unsigned idx,
                      input int unsigned last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= 3'(kind);
    s_tlast  <= 1'(last);
    s_tdata  <= {2'b00, 6'(idx), 16'(size), 16'(addr), 8'(sid), 8'(pid)};
    // ready is settled by the falling edge; the next rising edge takes the item
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // registers change only with the engine drained
  task automatic drain_and_config(input logic [15:0] msize, input logic pol);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    apb_write({REG_MEMORY_SIZE, 2'b00}, {16'($urandom), msize});
    apb_write({REG_FIT_POLICY, 2'b00}, {31'($urandom), pol});
    cur_mem = msize;
  endtask

  // mostly clear first, lay down a map, then run several processes against it
  task automatic run_scenario();
    int          nreg, hsz, nproc, nseg, cur;
    logic [7:0]  pid;
    logic [7:0]  used[$];
    if ($urandom_range(0, 5) != 0) send(RT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom);
    nreg = ($urandom_range(0, 11) == 0) ? 65 : $urandom_range(1, 10);
    hsz = (cur_mem / (nreg + 1) > 0) ? cur_mem / (nreg + 1) : 1;
    cur = $urandom_range(0, hsz / 4);
    for (int k = 0; k < nreg; k++) begin
      int sz, gp;
      sz = $urandom_range(0, hsz * 3 / 4);
      gp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hsz / 4) : 0;
      if ($urandom_range(0, 15) == 0)
        send(RT_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send(RT_APPEND, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : 0,
             $urandom, cur[15:0], sz[15:0], $urandom, $urandom);
      cur = cur + sz + gp;
    end
    nproc = $urandom_range(2, 8);
    for (int p = 0; p < nproc; p++) begin
      pid = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) pid = 0;
      used.push_back(pid);
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
        // now and then walk away before the last segment
        if (s == nseg - 1 && $urandom_range(0, 7) == 0) break;
        send(RT_ALLOC, pid, $urandom, $urandom, $urandom_range(0, hsz),
             $urandom, s == nseg - 1);
      end
      case ($urandom_range(0, 5))
        0: send(RT_FREE, used[$urandom_range(0, used.size() - 1)], $urandom, $urandom,
                $urandom, $urandom, $urandom);
        1: send(RT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
        default: ;
      endcase
    end
    for (int r = $urandom_range(0, 3); r > 0; r--)
      send(RT_READ, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 12), $urandom);
    if ($urandom_range(0, 1) == 0)
      send(RT_FREE, used[$urandom_range(0, used.size() - 1)], $urandom, $urandom, $urandom,
           $urandom, $urandom);
  endtask

  initial begin
    logic [15:0] msz[6] = '{16'd65535, 16'd65535, 16'd0, 16'd1000, 16'd40000, 16'd12345};
    logic        pol[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int          ph;
    rst = 1'b1;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0; s_tlast = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    no_idle = 0; items_sent = 0; cur_mem = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: map building, refusals, a failed process and its tail
    drain_and_config(16'd1000, 1'b0);
    send(RT_CLEAR,  0, 0, 0, 0, 0, 0);
    send(RT_APPEND, 0, 0, 16'd0, 16'd100, 0, 0);
    send(RT_APPEND, 9, 1, 16'd100, 16'd50, 0, 0);
    send(RT_APPEND, 0, 0, 16'd150, 16'd300, 0, 0);
    send(RT_APPEND, 0, 0, 16'd10, 16'd5, 0, 0);           // out of order
    send(RT_APPEND, 0, 0, 16'd500, 16'd600, 0, 0);        // past memory size
    send(RT_READ,   0, 0, 0, 0, 6'd0, 0);
    send(RT_READ,   0, 0, 0, 0, 6'd63, 0);                // beyond count
    send(RT_ALLOC,  0, 3, 0, 16'd10, 0, 1);               // process zero
    send(RT_ALLOC,  1, 0, 0, 16'd0, 0, 0);                // zero size
    send(RT_ALLOC,  1, 1, 0, 16'd100, 0, 0);
    send(RT_ALLOC,  1, 2, 0, 16'd5000, 0, 0);             // no fit, rolls back
    send(RT_ALLOC,  1, 3, 0, 16'd1, 0, 0);                // ignored
    send(RT_ALLOC,  1, 4, 0, 16'd1, 0, 1);                // ignored, closes
    send(RT_ALLOC,  2, 0, 0, 16'd30, 0, 0);
    send(RT_ALLOC,  3, 0, 0, 16'd20, 0, 1);               // abandons process 2
    send(RT_FREE,   9, 0, 0, 0, 0, 0);
    send(RT_READ,   0, 0, 0, 0, 6'd1, 0);
    send(RT_FREE,   3, 0, 0, 0, 0, 0);
    send(3'd5, 0, 0, 0, 0, 0, 0);
    send(3'd7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F, 1);
    drain_and_config(16'd65535, 1'b1);
    send(RT_CLEAR,  0, 0, 0, 0, 0, 0);
    send(RT_APPEND, 8'hFF, 8'hFF, 16'd0, 16'hFFFF, 0, 1);  // whole space
    send(RT_READ,   0, 0, 0, 0, 6'd0, 0);

    // random phases over a rotating set of settings
    ph = 0;
    while (items_sent < 1650) begin
      drain_and_config(msz[ph % 6], pol[ph % 6]);
      no_idle = (ph % 4 == 3);
      for (int n = 0; n < 6 && items_sent < 1650; n++) run_scenario();
      ph++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sfa_pkg.sv
rtl/sfa_ram.sv
rtl/sfa_front.sv
rtl/sfa_engine.sv
rtl/segment_fit_allocator.sv
dv/sfa_checker.sv
dv/tb_top.sv
